FILE: hw/rtl/egb_pkg.sv
// ----------------------------------------------------------------------------
// egb_pkg
// Shared widths and types for the extended gcd / Bezout coefficient block.
// ----------------------------------------------------------------------------
package egb_pkg;

   // Operand and coefficient widths
   localparam int OPERAND_WIDTH  = 32;
   localparam int COEF_WIDTH     = OPERAND_WIDTH + 1;
   localparam int STEP_CNT_WIDTH = $clog2(OPERAND_WIDTH);

   typedef logic        [OPERAND_WIDTH-1:0] operand_type;
   typedef logic signed [COEF_WIDTH-1:0]    coef_type;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: hw/rtl/egb_div_unit.sv
// ----------------------------------------------------------------------------
// egb_div_unit
// Restoring divider, one quotient bit per cycle. While the quotient bits are
// produced MSB first, two shift-add accumulators form quotient * mult_u and
// quotient * mult_v modulo 2^COEF_WIDTH, so no multiplier is needed.
// ----------------------------------------------------------------------------
module egb_div_unit import egb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  operand_type    dividend,
   input  operand_type    divisor,
   input  coef_type       mult_u,
   input  coef_type       mult_v,
   output div_status_type status,
   output operand_type    remainder,
   output coef_type       prod_u,
   output coef_type       prod_v
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   operand_type               part_ff, part_in;
   operand_type               dvd_ff, dvd_in;
   operand_type               dvsr_ff, dvsr_in;
   coef_type                  mul_u_ff, mul_u_in;
   coef_type                  mul_v_ff, mul_v_in;
   coef_type                  acc_u_ff, acc_u_in;
   coef_type                  acc_v_ff, acc_v_in;

   logic [OPERAND_WIDTH:0]    shifted;
   logic [OPERAND_WIDTH+1:0]  diff;
   logic                      q_bit;

   // Trial subtraction of the divisor from the shifted partial remainder
   assign shifted = {part_ff, dvd_ff[OPERAND_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
   assign q_bit   = ~diff[OPERAND_WIDTH+1];

   // Next-state logic
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      part_in  = part_ff;
      dvd_in   = dvd_ff;
      dvsr_in  = dvsr_ff;
      mul_u_in = mul_u_ff;
      mul_v_in = mul_v_ff;
      acc_u_in = acc_u_ff;
      acc_v_in = acc_v_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         part_in  = '0;
         dvd_in   = dividend;
         dvsr_in  = divisor;
         mul_u_in = mult_u;
         mul_v_in = mult_v;
         acc_u_in = '0;
         acc_v_in = '0;
      end else if (busy_ff) begin
         part_in  = q_bit ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
         dvd_in   = {dvd_ff[OPERAND_WIDTH-2:0], 1'b0};
         acc_u_in = {acc_u_ff[COEF_WIDTH-2:0], 1'b0} + (q_bit ? mul_u_ff : coef_type'(0));
         acc_v_in = {acc_v_ff[COEF_WIDTH-2:0], 1'b0} + (q_bit ? mul_v_ff : coef_type'(0));
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      part_ff  <= part_in;
      dvd_ff   <= dvd_in;
      dvsr_ff  <= dvsr_in;
      mul_u_ff <= mul_u_in;
      mul_v_ff <= mul_v_in;
      acc_u_ff <= acc_u_in;
      acc_v_ff <= acc_v_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = part_ff;
   assign prod_u      = acc_u_ff;
   assign prod_v      = acc_v_ff;

endmodule

FILE: hw/rtl/extended_gcd_bezout_top.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout_top
// Extended Euclidean algorithm: gcd of two unsigned operands and the Bezout
// coefficients u, v with a*u + b*v = gcd, in two's complement.
// ----------------------------------------------------------------------------
// One request at a time. Each Euclid step runs a check state, the
// bit-serial divider, which also builds quotient * coefficient by
// shift-add, and an update of the working registers. 32-bit operands
// need at most 47 steps. Both operands zero, or b zero, go from the
// check straight to the output state. The next request is taken once
// the response is in its output register, while that response still
// waits for rsp_ready.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_top import egb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  operand_type req_operand_a,
   input  operand_type req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output coef_type    rsp_coef_u,
   output coef_type    rsp_coef_v,
   output operand_type rsp_divisor_out
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   operand_type    rem_ff, rem_in;
   operand_type    rnext_ff, rnext_in;
   coef_type       cu_ff, cu_in;
   coef_type       cun_ff, cun_in;
   coef_type       cv_ff, cv_in;
   coef_type       cvn_ff, cvn_in;
   logic           rsp_valid_ff, rsp_valid_in;
   coef_type       rsp_u_ff, rsp_u_in;
   coef_type       rsp_v_ff, rsp_v_in;
   operand_type    rsp_gcd_ff, rsp_gcd_in;

   logic           div_start;
   div_status_type div_status;
   operand_type    div_rem;
   coef_type       div_prod_u;
   coef_type       div_prod_v;

   // Shared divider / multiply-accumulate unit
   egb_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rem_ff),
      .divisor   (rnext_ff),
      .mult_u    (cun_ff),
      .mult_v    (cvn_ff),
      .status    (div_status),
      .remainder (div_rem),
      .prod_u    (div_prod_u),
      .prod_v    (div_prod_v)
   );

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      rnext_in     = rnext_ff;
      cu_in        = cu_ff;
      cun_in       = cun_ff;
      cv_in        = cv_ff;
      cvn_in       = cvn_ff;
      rsp_u_in     = rsp_u_ff;
      rsp_v_in     = rsp_v_ff;
      rsp_gcd_in   = rsp_gcd_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in   = req_operand_a;
               rnext_in = req_operand_b;
               cu_in    = coef_type'(1);
               cun_in   = coef_type'(0);
               cv_in    = coef_type'(0);
               cvn_in   = coef_type'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rnext_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // (r, r') <- (r', r mod r'), coefficients likewise
            if (div_status.done) begin
               rem_in   = rnext_ff;
               rnext_in = div_rem;
               cu_in    = cun_ff;
               cun_in   = cu_ff - div_prod_u;
               cv_in    = cvn_ff;
               cvn_in   = cv_ff - div_prod_v;
               state_in = ST_CHECK;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_u_in     = cu_ff;
               rsp_v_in     = cv_ff;
               rsp_gcd_in   = rem_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      rnext_ff   <= rnext_in;
      cu_ff      <= cu_in;
      cun_ff     <= cun_in;
      cv_ff      <= cv_in;
      cvn_ff     <= cvn_in;
      rsp_u_ff   <= rsp_u_in;
      rsp_v_ff   <= rsp_v_in;
      rsp_gcd_ff <= rsp_gcd_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coef_u      = rsp_u_ff;
   assign rsp_coef_v      = rsp_v_ff;
   assign rsp_divisor_out = rsp_gcd_ff;

`ifndef NO_ASSERTIONS
   // Divider sits idle whenever no request is in progress
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_status.busy && !div_status.done)
      else $error("divider active while idle");

   // Divider results only arrive while the sequencer waits for them
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider done outside division state");

   // Zero remainder ends the loop
   a_check_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && rnext_ff == '0 |=> state_ff == ST_OUT)
      else $error("loop did not end on zero remainder");

   // An accepted request always starts with the loop check
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted request did not enter check");
`endif

endmodule

FILE: tb/tb_extended_gcd_bezout_top.sv
// ----------------------------------------------------------------------------
// tb_extended_gcd_bezout_top
// Self-checking bench for the extended gcd / Bezout block. Requests go in
// through a valid/ready port. Each accepted request is run through a
// behavioural Euclid loop in a small scoreboard, and every response is
// compared field by field against the oldest prediction. A directed set
// covers zero operands, extremes and Fibonacci worst cases. A random set
// follows, mixing full-width, narrow, common-factor, multiple and
// near-maximum operands. Both sides stall at random, and once the receiver
// holds off for a long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------

class bezout_scoreboard;

   typedef struct {
      egb_pkg::coef_type    coef_u;
      egb_pkg::coef_type    coef_v;
      egb_pkg::operand_type gcd;
   } bezout_result_type;

   bezout_result_type expected_q[$];
   int                failures;

   function new();
      failures = 0;
   endfunction

   // Euclid loop in 64-bit arithmetic, coefficients cut to the output width
   function bezout_result_type predict_bezout(egb_pkg::operand_type a,
                                              egb_pkg::operand_type b);
      logic [63:0]       rem, rem_nxt, cu, cu_nxt, cv, cv_nxt, quot, tmp;
      bezout_result_type res;
      rem     = a;
      rem_nxt = b;
      cu      = 64'd1;
      cu_nxt  = 64'd0;
      cv      = 64'd0;
      cv_nxt  = 64'd1;
      while (rem_nxt != 64'd0) begin
         quot    = rem / rem_nxt;
         tmp     = rem - quot * rem_nxt;
         rem     = rem_nxt;
         rem_nxt = tmp;
         tmp     = cu - quot * cu_nxt;
         cu      = cu_nxt;
         cu_nxt  = tmp;
         tmp     = cv - quot * cv_nxt;
         cv      = cv_nxt;
         cv_nxt  = tmp;
      end
      res.coef_u = cu[egb_pkg::COEF_WIDTH-1:0];
      res.coef_v = cv[egb_pkg::COEF_WIDTH-1:0];
      res.gcd    = rem[egb_pkg::OPERAND_WIDTH-1:0];
      return res;
   endfunction

   function void note_request(egb_pkg::operand_type a, egb_pkg::operand_type b);
      expected_q.insert(expected_q.size(), predict_bezout(a, b));
   endfunction

   function void check_response(egb_pkg::coef_type u, egb_pkg::coef_type v,
                                egb_pkg::operand_type g);
      bezout_result_type exp_res;
      if (expected_q.size() == 0) begin
         $error("unexpected response: coef_u %0d coef_v %0d divisor_out %0d", u, v, g);
         failures++;
         return;
      end
      exp_res = expected_q.pop_front();
      if (u !== exp_res.coef_u) begin
         $error("coef_u: expected %0d, got %0d", exp_res.coef_u, u);
         failures++;
      end
      if (v !== exp_res.coef_v) begin
         $error("coef_v: expected %0d, got %0d", exp_res.coef_v, v);
         failures++;
      end
      if (g !== exp_res.gcd) begin
         $error("divisor_out: expected %0d, got %0d", exp_res.gcd, g);
         failures++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module tb_extended_gcd_bezout_top;
   import egb_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_ITEMS  = 350;
   localparam int SETTLE_CYCLES = 1700;
   localparam int IDLE_PCT      = 6;
   // window of requests / responses with no idling on either side
   localparam int QUIET_FIRST   = 200;
   localparam int QUIET_LAST    = 260;
   // long receiver hold-off once this many responses have come back
   localparam int HOLD_AT_RSP   = 100;
   localparam int HOLD_CYCLES   = 3000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   operand_type req_operand_a;
   operand_type req_operand_b;
   logic        rsp_valid;
   logic        rsp_ready;
   coef_type    rsp_coef_u;
   coef_type    rsp_coef_v;
   operand_type rsp_divisor_out;

   bezout_scoreboard bezout_sb = new();
   int               req_count;
   int               rsp_count;
   int               cycle_count;

   extended_gcd_bezout_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coef_u      (rsp_coef_u),
      .rsp_coef_v      (rsp_coef_v),
      .rsp_divisor_out (rsp_divisor_out)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request, with random idle cycles ahead of it, and wait for it
   task automatic send_request(input operand_type a, input operand_type b);
      while (!(req_count >= QUIET_FIRST && req_count < QUIET_LAST) &&
             $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      bezout_sb.note_request(a, b);
      req_count++;
   endtask

   // Zero operands, extremes, Fibonacci worst case, big primes
   task automatic run_directed();
      send_request(32'h0000_0000, 32'h0000_0000);   // both zero
      send_request(32'd12345,     32'h0000_0000);   // b zero
      send_request(32'h0000_0000, 32'd67890);       // a zero
      send_request(32'hFFFF_FFFF, 32'h0000_0000);
      send_request(32'h0000_0000, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'h0000_0001);
      send_request(32'h0000_0001, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_request(32'h8000_0000, 32'h4000_0000);
      send_request(32'd2971215073, 32'd1836311903); // Fibonacci pair, longest Euclid chain with a > b
      send_request(32'd1836311903, 32'd2971215073);
      send_request(32'd1,          32'd1);
      send_request(32'd240,        32'd46);
      send_request(32'd46,         32'd240);
      send_request(32'd4294967291, 32'd4294967279); // two large primes
      send_request(32'hAAAA_AAAA, 32'h5555_5555);
      send_request(32'd7,          32'd7);
      send_request(32'd1000000007, 32'd998244353);
      send_request(32'd12,         32'd18);
   endtask

   // Mixed random operand classes
   task automatic run_random();
      operand_type a, b, lo, hi, tmp;
      int unsigned pick, g;
      int          k;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            a = $urandom;
            b = $urandom;
         end else if (pick < 50) begin
            // narrow operands keep most requests short
            a = $urandom >> $urandom_range(0, 31);
            b = $urandom >> $urandom_range(0, 31);
         end else if (pick < 65) begin
            g = $urandom_range(1, 65535);
            a = g * $urandom_range(0, 65535);
            b = g * $urandom_range(0, 65535);
         end else if (pick < 75) begin
            // consecutive Fibonacci numbers
            k  = $urandom_range(1, 46);
            lo = 1;
            hi = 1;
            repeat (k - 1) begin
               tmp = lo + hi;
               lo  = hi;
               hi  = tmp;
            end
            if ($urandom_range(1)) begin
               a = hi;
               b = lo;
            end else begin
               a = lo;
               b = hi;
            end
         end else if (pick < 85) begin
            // one operand a multiple of the other
            b = $urandom_range(1, 65535);
            a = b * $urandom_range(0, 65535);
            if ($urandom_range(1)) begin
               tmp = a;
               a   = b;
               b   = tmp;
            end
         end else if (pick < 92) begin
            a = $urandom;
            case ($urandom_range(2))
               0: b = 32'h0000_0000;
               1: begin
                  b = a;
                  a = 32'h0000_0000;
               end
               default: b = a;
            endcase
         end else begin
            a = ~$urandom_range(0, 255);
            b = ~$urandom_range(0, 255);
         end
         send_request(a, b);
      end
   endtask

   // Stimulus and end of run
   initial begin
      req_count     = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (bezout_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bezout_sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: check, random stalls, one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_count = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            bezout_sb.check_response(rsp_coef_u, rsp_coef_v, rsp_divisor_out);
            rsp_count++;
         end
         if (!hold_done && rsp_count == HOLD_AT_RSP) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_count >= QUIET_FIRST && rsp_count < QUIET_LAST) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
